// ===== sv/tcp_option_list_parser_core_macros.svh =====
`ifndef TCP_OPTION_LIST_PARSER_CORE_MACROS_SVH
`define TCP_OPTION_LIST_PARSER_CORE_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TOLP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TOLP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tolp_pkg.sv =====
`timescale 1ns / 1ps

package tolp_pkg;

    localparam logic [5:0] MAX_OPTION_AREA = 6'd40;
    localparam logic [7:0] WSCALE_MAX      = 8'd14;
    localparam logic [7:0] AUTH_MIN_LEN    = 8'd4;
    localparam logic [7:0] OPT_HDR_LEN     = 8'd2;

    localparam logic [7:0] KIND_EOL    = 8'd0;
    localparam logic [7:0] KIND_NOP    = 8'd1;
    localparam logic [7:0] KIND_WSCALE = 8'd3;
    localparam logic [7:0] KIND_SACK   = 8'd5;
    localparam logic [7:0] KIND_AUTH   = 8'd29;

    localparam logic [2:0] CF_EXP  = 3'b001;
    localparam logic [2:0] CF_OBS  = 3'b010;
    localparam logic [2:0] CF_TTCP = 3'b100;

    typedef enum logic [1:0] {
        PH_KIND = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADLEN = 2'd1,
        ST_TRUNC  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_EXP  = 2'd1,
        CLS_OBS  = 2'd2,
        CLS_TTCP = 2'd3
    } t_class;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] kind;
        logic [5:0] bytes_left;
        logic [5:0] pos;
        logic [5:0] vcount;
        logic [2:0] cflags;
        t_status    err;
        logic       stopped;
        logic [5:0] decl_len;
    } t_state;

    localparam t_state STATE_RESET = '{PH_KIND, 8'd0, 6'd0, 6'd0, 6'd0, 3'd0,
                                       ST_OK, 1'b0, 6'd0};

    typedef struct packed {
        logic       opt_valid;
        logic [7:0] kind;
        logic [5:0] data_len;
        logic       wscale_big;
        logic       done;
        t_status    status;
        logic [5:0] count;
        t_class     cls;
    } t_result;

    // 0 for kinds of variable length
    function automatic logic [7:0] fixed_len(input logic [7:0] k);
        case (k)
            8'd2:                return 8'd4;
            8'd3:                return 8'd3;
            8'd4:                return 8'd2;
            8'd6, 8'd7:          return 8'd6;
            8'd8:                return 8'd10;
            8'd11, 8'd12, 8'd13: return 8'd6;
            8'd18:               return 8'd3;
            8'd19:               return 8'd18;
            default:             return 8'd0;
        endcase
    endfunction

    function automatic logic [2:0] kind_class(input logic [7:0] k);
        case (k)
            8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd8, 8'd11, 8'd12, 8'd29:
                return 3'b000;
            8'd13:
                return CF_TTCP;
            8'd6, 8'd7, 8'd16, 8'd17, 8'd19, 8'd25:
                return CF_OBS;
            default:
                return CF_EXP;
        endcase
    endfunction

    function automatic t_state fail_st(input t_state s, input t_status st);
        t_state r;
        r = s;
        r.err = st;
        r.stopped = 1'b1;
        r.phase = PH_KIND;
        return r;
    endfunction

    function automatic t_state good_st(input t_state s);
        t_state r;
        r = s;
        if (r.vcount != 6'h3F) begin
            r.vcount = r.vcount + 6'd1;
        end
        r.phase = PH_KIND;
        return r;
    endfunction

endpackage

// ===== sv/tolp_in_reg.sv =====
`timescale 1ns / 1ps

module tolp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_opt_byte,
    input  logic [5:0] i_area_length,
    input  logic       i_first_byte,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_opt_byte,
    output logic [5:0] o_area_length,
    output logic       o_first_byte
);

    logic       r_valid;
    logic [7:0] r_opt_byte;
    logic [5:0] r_area_length;
    logic       r_first_byte;

    assign o_ready       = !r_valid || i_advance;
    assign o_valid       = r_valid;
    assign o_opt_byte    = r_opt_byte;
    assign o_area_length = r_area_length;
    assign o_first_byte  = r_first_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_opt_byte    <= i_opt_byte;
            r_area_length <= i_area_length;
            r_first_byte  <= i_first_byte;
        end
    end

endmodule

// ===== sv/tolp_step.sv =====
`timescale 1ns / 1ps

module tolp_step (
    input  tolp_pkg::t_state  i_state,
    input  logic [7:0]        i_opt_byte,
    input  logic [5:0]        i_area_length,
    input  logic              i_first_byte,
    output tolp_pkg::t_state  o_state,
    output tolp_pkg::t_result o_result,
    output logic              o_emit
);

    tolp_pkg::t_state  eff;
    tolp_pkg::t_state  ns;
    tolp_pkg::t_result res;
    logic              bad;
    logic              last;
    logic [5:0]        lim;
    logic [7:0]        rem;
    logic [7:0]        flen;
    logic [5:0]        bl;
    logic              emit;

    always_comb begin
        eff  = i_first_byte ? tolp_pkg::STATE_RESET : i_state;
        ns   = eff;
        res  = '0;
        emit = 1'b0;
        bad  = (i_area_length == 6'd0) || (i_area_length > tolp_pkg::MAX_OPTION_AREA);
        lim  = bad ? 6'd1 : i_area_length;
        last = ({1'b0, eff.pos} + 7'd1) == {1'b0, lim};
        rem  = {2'b00, i_area_length} + 8'd1 - {2'b00, eff.pos};
        flen = tolp_pkg::fixed_len(eff.kind);
        bl   = eff.bytes_left;

        if (eff.pos < lim) begin
            if (bad) begin
                ns.vcount = 6'd0;
                ns = tolp_pkg::fail_st(ns, tolp_pkg::ST_BADLEN);
            end else if (!eff.stopped) begin
                case (eff.phase)
                    tolp_pkg::PH_KIND: begin
                        ns.cflags = eff.cflags | tolp_pkg::kind_class(i_opt_byte);
                        if (i_opt_byte == tolp_pkg::KIND_EOL ||
                            i_opt_byte == tolp_pkg::KIND_NOP) begin
                            ns = tolp_pkg::good_st(ns);
                            res.opt_valid = 1'b1;
                            res.kind = i_opt_byte;
                            emit = 1'b1;
                            if (i_opt_byte == tolp_pkg::KIND_EOL) begin
                                ns.stopped = 1'b1;
                            end
                        end else if ((i_area_length - eff.pos) < 6'd2) begin
                            ns = tolp_pkg::fail_st(ns, tolp_pkg::ST_TRUNC);
                        end else begin
                            ns.kind = i_opt_byte;
                            ns.phase = tolp_pkg::PH_LEN;
                        end
                    end
                    tolp_pkg::PH_LEN: begin
                        if (eff.kind == tolp_pkg::KIND_AUTH &&
                            i_opt_byte < tolp_pkg::AUTH_MIN_LEN) begin
                            ns = tolp_pkg::fail_st(ns, tolp_pkg::ST_BADLEN);
                        end else if (flen != 8'd0 && i_opt_byte == 8'd0) begin
                            ns = tolp_pkg::fail_st(ns, tolp_pkg::ST_BADLEN);
                        end else if (flen != 8'd0 && flen > rem) begin
                            ns = tolp_pkg::fail_st(ns, tolp_pkg::ST_TRUNC);
                        end else if (flen != 8'd0 && i_opt_byte != flen) begin
                            ns = tolp_pkg::fail_st(ns, tolp_pkg::ST_BADLEN);
                        end else if (flen == 8'd0 && i_opt_byte < tolp_pkg::OPT_HDR_LEN) begin
                            ns = tolp_pkg::fail_st(ns, tolp_pkg::ST_BADLEN);
                        end else if (flen == 8'd0 && i_opt_byte > rem) begin
                            ns = tolp_pkg::fail_st(ns, tolp_pkg::ST_TRUNC);
                        end else if (eff.kind == tolp_pkg::KIND_SACK &&
                                     i_opt_byte == tolp_pkg::OPT_HDR_LEN) begin
                            ns = tolp_pkg::fail_st(ns, tolp_pkg::ST_BADLEN);
                        end else begin
                            ns.decl_len = i_opt_byte[5:0];
                            if (i_opt_byte == tolp_pkg::OPT_HDR_LEN) begin
                                ns = tolp_pkg::good_st(ns);
                                res.opt_valid = 1'b1;
                                res.kind = eff.kind;
                                emit = 1'b1;
                            end else begin
                                ns.bytes_left = i_opt_byte[5:0] - tolp_pkg::OPT_HDR_LEN[5:0];
                                ns.phase = tolp_pkg::PH_DATA;
                            end
                        end
                    end
                    tolp_pkg::PH_DATA: begin
                        if (bl != 6'd0) begin
                            bl = bl - 6'd1;
                        end
                        ns.bytes_left = bl;
                        if (bl == 6'd0) begin
                            ns = tolp_pkg::good_st(ns);
                            res.opt_valid = 1'b1;
                            res.kind = eff.kind;
                            res.data_len = eff.decl_len - tolp_pkg::OPT_HDR_LEN[5:0];
                            res.wscale_big = (eff.kind == tolp_pkg::KIND_WSCALE) &&
                                             (i_opt_byte > tolp_pkg::WSCALE_MAX);
                            emit = 1'b1;
                        end
                    end
                    default: begin
                        ns = eff;
                    end
                endcase
            end
            ns.pos = eff.pos + 6'd1;

            if (last) begin
                if (!ns.stopped && ns.phase != tolp_pkg::PH_KIND) begin
                    ns = tolp_pkg::fail_st(ns, tolp_pkg::ST_TRUNC);
                end
                res.done = 1'b1;
                res.status = ns.err;
                res.count = ns.vcount;
                res.cls = tolp_pkg::CLS_NONE;
                if (ns.err == tolp_pkg::ST_OK) begin
                    if ((ns.cflags & tolp_pkg::CF_EXP) != 3'd0) begin
                        res.cls = tolp_pkg::CLS_EXP;
                    end else if ((ns.cflags & tolp_pkg::CF_OBS) != 3'd0) begin
                        res.cls = tolp_pkg::CLS_OBS;
                    end else if ((ns.cflags & tolp_pkg::CF_TTCP) != 3'd0) begin
                        res.cls = tolp_pkg::CLS_TTCP;
                    end
                end
                emit = 1'b1;
            end
        end
    end

    assign o_state  = ns;
    assign o_result = res;
    assign o_emit   = emit;

endmodule

// ===== sv/tcp_option_list_parser_core.sv =====
// channel | dir | tdata (low bit up)                          | tuser      | tlast
// s_axis  | in  | opt_byte[7:0], area_length[13:8]            | first_byte | -
// m_axis  | out | option_valid, option_kind, option_data_len,  | -          | area_done
//         |     | wscale_too_big, parse_status, option_count, |            |
//         |     | option_class (bits 25:0)                    |            |
// One byte per cycle sustained while m_axis is not stalled.
// The byte register feeds one step of parse logic into the result register.
// i_rst_n (synchronous) empties both registers and returns to a fresh area.
// A stalled m_axis holds the byte register; s_axis_tready is high while it is empty or advances.
// Bytes that give no result are consumed without an output transfer.
`timescale 1ns / 1ps
`include "tcp_option_list_parser_core_macros.svh"

module tcp_option_list_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // opt_byte, area_length
    input  logic [0:0]  s_axis_tuser,   // first_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // option_valid, option_kind, option_data_len,
                                        // wscale_too_big, parse_status, option_count,
                                        // option_class
    output logic        m_axis_tlast    // area_done
);

    logic              in_valid;
    logic [7:0]        in_byte;
    logic [5:0]        in_alen;
    logic              in_first;
    logic              advance;
    logic              emit;
    tolp_pkg::t_state  n_state;
    tolp_pkg::t_result n_result;

    tolp_pkg::t_state  r_state;
    logic              r_out_valid;
    tolp_pkg::t_result r_out;

    assign advance = in_valid && (!r_out_valid || m_axis_tready);

    tolp_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_opt_byte    (s_axis_tdata[7:0]),
        .i_area_length (s_axis_tdata[13:8]),
        .i_first_byte  (s_axis_tuser[0]),
        .i_advance     (advance),
        .o_valid       (in_valid),
        .o_opt_byte    (in_byte),
        .o_area_length (in_alen),
        .o_first_byte  (in_first)
    );

    tolp_step u_step (
        .i_state       (r_state),
        .i_opt_byte    (in_byte),
        .i_area_length (in_alen),
        .i_first_byte  (in_first),
        .o_state       (n_state),
        .o_result      (n_result),
        .o_emit        (emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tolp_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance && emit) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.done;
    assign m_axis_tdata  = {6'd0, r_out.cls, r_out.count, r_out.status, r_out.wscale_big,
                            r_out.data_len, r_out.kind, r_out.opt_valid};

    `TOLP_ASSERT_IMP(a_class_only_ok,
        m_axis_tvalid && r_out.cls != tolp_pkg::CLS_NONE,
        r_out.done && r_out.status == tolp_pkg::ST_OK,
        "option class reported with a failed status")
    `TOLP_ASSERT_IMP(a_summary_zero,
        m_axis_tvalid && !r_out.done,
        r_out.count == 6'd0 && r_out.status == tolp_pkg::ST_OK,
        "summary fields set on a result that is not the last")
    `TOLP_ASSERT_IMP(a_option_zero,
        m_axis_tvalid && !r_out.opt_valid,
        r_out.kind == 8'd0 && r_out.data_len == 6'd0 && !r_out.wscale_big,
        "option fields set without a valid option")
    `TOLP_ASSERT_IMP(a_pos_bound,
        1'b1,
        r_state.pos <= tolp_pkg::MAX_OPTION_AREA,
        "area position beyond the largest area")
    `TOLP_ASSERT_NXT(a_stall_holds_state,
        in_valid && r_out_valid && !m_axis_tready,
        r_state == $past(r_state),
        "parse state moved while the result was stalled")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_BYTES = 830;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RX_LONG_HOLD = 80;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    tcp_option_list_parser_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    typedef struct {
        logic [7:0]        b;
        logic [5:0]        al;
        logic              fb;
        bit                typed;
        bit                t_has;
        tolp_pkg::t_result t_r;
    } t_row;

    // parser state as the block should hold it
    tolp_pkg::t_phase  ph;
    logic [7:0]        cur_kind;
    logic [5:0]        left_bytes;
    int                pos;
    logic [5:0]        n_good;
    logic [2:0]        cls_bits;
    tolp_pkg::t_status err;
    bit                halted;
    logic [5:0]        data_len;

    tolp_pkg::t_result option_reports_q[$];
    t_row              dir_rows[$];
    logic [7:0]        area_bytes[$];
    int                n_mismatch  = 0;
    int                n_used      = 0;
    int                cycles      = 0;
    bit                quiet_tail  = 1'b0;
    bit                hold_rx_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] len_of(input logic [7:0] k);
        logic [7:0] n;
        n = 8'd0;
        case (k)
            8'd2:                n = 8'd4;
            8'd3, 8'd18:         n = 8'd3;
            8'd4:                n = 8'd2;
            8'd6, 8'd7, 8'd11,
            8'd12, 8'd13:        n = 8'd6;
            8'd8:                n = 8'd10;
            8'd19:               n = 8'd18;
            default:             n = 8'd0;
        endcase
        return n;
    endfunction

    function automatic logic [2:0] class_of(input logic [7:0] k);
        logic [2:0] c;
        c = tolp_pkg::CF_EXP;
        if (k <= 8'd5 || k == 8'd8 || k == 8'd11 || k == 8'd12 || k == tolp_pkg::KIND_AUTH)
            c = 3'b000;
        else if (k == 8'd13)
            c = tolp_pkg::CF_TTCP;
        else if (k == 8'd6 || k == 8'd7 || k == 8'd16 || k == 8'd17 || k == 8'd19
                 || k == 8'd25)
            c = tolp_pkg::CF_OBS;
        return c;
    endfunction

    task automatic clear_parser();
        ph         = tolp_pkg::PH_KIND;
        cur_kind   = '0;
        left_bytes = '0;
        pos        = 0;
        n_good     = '0;
        cls_bits   = '0;
        err        = tolp_pkg::ST_OK;
        halted     = 1'b0;
        data_len   = '0;
    endtask

    task automatic stop_with(input tolp_pkg::t_status st);
        err    = st;
        halted = 1'b1;
        ph     = tolp_pkg::PH_KIND;
    endtask

    task automatic report_option(inout tolp_pkg::t_result r, input logic [7:0] k,
                                 input logic [5:0] dl, input logic ws);
        r.opt_valid  = 1'b1;
        r.kind       = k;
        r.data_len   = dl;
        r.wscale_big = ws;
        if (n_good != 6'h3F) begin
            n_good = n_good + 6'd1;
        end
        ph = tolp_pkg::PH_KIND;
    endtask

    task automatic parse_option_byte(input logic [7:0] b, input logic [5:0] al,
                                     input logic fb, output bit used, output bit has,
                                     output tolp_pkg::t_result r);
        int lim;
        int rem;
        int want;
        bit bad;
        bit last;
        r    = '0;
        has  = 1'b0;
        used = 1'b0;
        if (fb) begin
            clear_parser();
        end
        bad = (al == 6'd0) || (al > tolp_pkg::MAX_OPTION_AREA);
        lim = bad ? 1 : int'(al);
        if (pos < lim) begin
            used = 1'b1;
            last = (pos + 1 == lim);
            if (bad) begin
                n_good = '0;
                stop_with(tolp_pkg::ST_BADLEN);
            end else if (!halted) begin
                case (ph)
                    tolp_pkg::PH_KIND: begin
                        cls_bits = cls_bits | class_of(b);
                        if (b == tolp_pkg::KIND_EOL || b == tolp_pkg::KIND_NOP) begin
                            report_option(r, b, 6'd0, 1'b0);
                            has = 1'b1;
                            if (b == tolp_pkg::KIND_EOL) halted = 1'b1;
                        end else if (int'(al) - pos < 2) begin
                            stop_with(tolp_pkg::ST_TRUNC);
                        end else begin
                            cur_kind = b;
                            ph = tolp_pkg::PH_LEN;
                        end
                    end
                    tolp_pkg::PH_LEN: begin
                        rem  = int'(al) + 1 - pos;
                        want = int'(len_of(cur_kind));
                        if (cur_kind == tolp_pkg::KIND_AUTH && b < tolp_pkg::AUTH_MIN_LEN)
                            stop_with(tolp_pkg::ST_BADLEN);
                        else if (want != 0 && b == 8'd0)
                            stop_with(tolp_pkg::ST_BADLEN);
                        else if (want != 0 && want > rem)
                            stop_with(tolp_pkg::ST_TRUNC);
                        else if (want != 0 && int'(b) != want)
                            stop_with(tolp_pkg::ST_BADLEN);
                        else if (want == 0 && b < tolp_pkg::OPT_HDR_LEN)
                            stop_with(tolp_pkg::ST_BADLEN);
                        else if (want == 0 && int'(b) > rem)
                            stop_with(tolp_pkg::ST_TRUNC);
                        else if (cur_kind == tolp_pkg::KIND_SACK && b == tolp_pkg::OPT_HDR_LEN)
                            stop_with(tolp_pkg::ST_BADLEN);
                        else begin
                            data_len = 6'(b - tolp_pkg::OPT_HDR_LEN);
                            if (b == tolp_pkg::OPT_HDR_LEN) begin
                                report_option(r, cur_kind, 6'd0, 1'b0);
                                has = 1'b1;
                            end else begin
                                left_bytes = data_len;
                                ph = tolp_pkg::PH_DATA;
                            end
                        end
                    end
                    default: begin
                        if (left_bytes != 6'd0) left_bytes = left_bytes - 6'd1;
                        if (left_bytes == 6'd0) begin
                            report_option(r, cur_kind, data_len,
                                          cur_kind == tolp_pkg::KIND_WSCALE &&
                                          b > tolp_pkg::WSCALE_MAX);
                            has = 1'b1;
                        end
                    end
                endcase
            end
            pos++;
            if (last) begin
                if (!halted && ph != tolp_pkg::PH_KIND) stop_with(tolp_pkg::ST_TRUNC);
                r.done   = 1'b1;
                r.status = err;
                r.count  = n_good;
                r.cls    = tolp_pkg::CLS_NONE;
                if (err == tolp_pkg::ST_OK) begin
                    if (cls_bits & tolp_pkg::CF_EXP)       r.cls = tolp_pkg::CLS_EXP;
                    else if (cls_bits & tolp_pkg::CF_OBS)  r.cls = tolp_pkg::CLS_OBS;
                    else if (cls_bits & tolp_pkg::CF_TTCP) r.cls = tolp_pkg::CLS_TTCP;
                end
                has = 1'b1;
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic [5:0] al, input logic fb,
                             output bit used, output bit has, output tolp_pkg::t_result r);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, al, b};
        s_axis_tuser  <= fb;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        parse_option_byte(b, al, fb, used, has, r);
    endtask

    task automatic feed(input logic [7:0] b, input logic [5:0] al, input logic fb);
        bit                used;
        bit                has;
        tolp_pkg::t_result r;
        send_byte(b, al, fb, used, has, r);
        if (has) option_reports_q = {option_reports_q, r};
        if (used) n_used++;
    endtask

    function automatic tolp_pkg::t_result summary_of(input tolp_pkg::t_status st,
                                                     input logic [5:0] n,
                                                     input tolp_pkg::t_class c);
        tolp_pkg::t_result r;
        r        = '0;
        r.done   = 1'b1;
        r.status = st;
        r.count  = n;
        r.cls    = c;
        return r;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic [5:0] al,
                                    input logic fb, input bit typed, input bit t_has,
                                    input tolp_pkg::t_result t_r);
        t_row w;
        w.b     = b;
        w.al    = al;
        w.fb    = fb;
        w.typed = typed;
        w.t_has = t_has;
        w.t_r   = t_r;
        dir_rows = {dir_rows, w};
    endfunction

    task automatic load_directed();
        tolp_pkg::t_result tr;
        // end of list straight after reset, no first-byte marker
        tr = summary_of(tolp_pkg::ST_OK, 6'd1, tolp_pkg::CLS_NONE);
        tr.opt_valid = 1'b1;
        add_row(tolp_pkg::KIND_EOL, 6'd1, 1'b0, 1'b1, 1'b1, tr);
        // illegal area lengths
        add_row(8'hFF, 6'd0, 1'b1, 1'b1, 1'b1,
                summary_of(tolp_pkg::ST_BADLEN, 6'd0, tolp_pkg::CLS_NONE));
        add_row(8'hFF, 6'd0, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h00, 6'd63, 1'b1, 1'b1, 1'b1,
                summary_of(tolp_pkg::ST_BADLEN, 6'd0, tolp_pkg::CLS_NONE));
        add_row(8'h01, 6'd41, 1'b1, 1'b1, 1'b1,
                summary_of(tolp_pkg::ST_BADLEN, 6'd0, tolp_pkg::CLS_NONE));
        // kind on the last byte
        add_row(tolp_pkg::KIND_SACK, 6'd1, 1'b1, 1'b1, 1'b1,
                summary_of(tolp_pkg::ST_TRUNC, 6'd0, tolp_pkg::CLS_NONE));
        // window scale shift too large, then padding
        add_row(tolp_pkg::KIND_WSCALE, 6'd4, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'd3, 6'd4, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'd15, 6'd4, 1'b0, 1'b0, 1'b0, '0);
        add_row(tolp_pkg::KIND_NOP, 6'd4, 1'b0, 1'b0, 1'b0, '0);
        // short auth, bytes after the stop
        add_row(tolp_pkg::KIND_AUTH, 6'd4, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'd3, 6'd4, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'd0, 6'd4, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'd0, 6'd4, 1'b0, 1'b1, 1'b1,
                summary_of(tolp_pkg::ST_BADLEN, 6'd0, tolp_pkg::CLS_NONE));
        // sack without blocks
        add_row(tolp_pkg::KIND_SACK, 6'd2, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'd2, 6'd2, 1'b0, 1'b1, 1'b1,
                summary_of(tolp_pkg::ST_BADLEN, 6'd0, tolp_pkg::CLS_NONE));
        // zero length
        add_row(8'd2, 6'd2, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'd0, 6'd2, 1'b0, 1'b1, 1'b1,
                summary_of(tolp_pkg::ST_BADLEN, 6'd0, tolp_pkg::CLS_NONE));
        // unknown kind with one data byte, nop, end of list
        add_row(8'd254, 6'd5, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'd3, 6'd5, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hAA, 6'd5, 1'b0, 1'b0, 1'b0, '0);
        add_row(tolp_pkg::KIND_NOP, 6'd5, 1'b0, 1'b0, 1'b0, '0);
        tr = summary_of(tolp_pkg::ST_OK, 6'd3, tolp_pkg::CLS_EXP);
        tr.opt_valid = 1'b1;
        add_row(tolp_pkg::KIND_EOL, 6'd5, 1'b0, 1'b1, 1'b1, tr);
    endtask

    task automatic build_area(input int alen);
        int         l;
        int         i;
        int         sel;
        logic [7:0] kd;
        logic [7:0] shift;
        area_bytes.delete();
        while (area_bytes.size() < alen) begin
            sel = $urandom_range(0, 15);
            l   = 1;
            case (sel)
                0: kd = tolp_pkg::KIND_NOP;
                1: kd = tolp_pkg::KIND_EOL;
                2: begin kd = 8'd2; l = 4; end
                3: begin kd = tolp_pkg::KIND_WSCALE; l = 3; end
                4: begin kd = 8'd4; l = 2; end
                5: begin kd = tolp_pkg::KIND_SACK; l = 2 + 8 * $urandom_range(1, 4); end
                6: begin kd = 8'($urandom_range(6, 7)); l = 6; end
                7: begin kd = 8'd8; l = 10; end
                8: begin kd = 8'($urandom_range(11, 13)); l = 6; end
                9: begin kd = 8'd18; l = 3; end
                10: begin kd = 8'd19; l = 18; end
                11: begin kd = tolp_pkg::KIND_AUTH; l = $urandom_range(4, 12); end
                12: begin
                    sel = $urandom_range(0, 2);
                    kd = (sel == 0) ? 8'd16 : (sel == 1) ? 8'd17 : 8'd25;
                    l = $urandom_range(2, 8);
                end
                default: begin
                    kd = 8'($urandom_range(9, 255));
                    if (len_of(kd) != 8'd0 || kd == tolp_pkg::KIND_AUTH) kd = 8'd20;
                    l = $urandom_range(2, 10);
                end
            endcase
            if (l > alen - area_bytes.size() && $urandom_range(0, 3) != 0) begin
                kd = tolp_pkg::KIND_NOP;
                l  = 1;
            end
            area_bytes = {area_bytes, kd};
            if (l >= 2) area_bytes = {area_bytes, 8'(l)};
            shift = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 14))
                                                : 8'($urandom_range(15, 255));
            for (i = 2; i < l; i++) begin
                area_bytes = {area_bytes, (kd == tolp_pkg::KIND_WSCALE) ? shift
                                                     : 8'($urandom_range(0, 255))};
            end
        end
        while (area_bytes.size() > alen) void'(area_bytes.pop_back());
        if ($urandom_range(0, 5) == 0) begin
            area_bytes[$urandom_range(0, alen - 1)] = 8'($urandom_range(0, 255));
        end
    endtask

    task automatic send_area();
        int         alen;
        int         kind_sel;
        int         i;
        logic [5:0] al;
        bit         drift;
        bit         no_first;
        kind_sel = $urandom_range(0, 19);
        alen = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 14);
        drift    = (kind_sel == 17);
        no_first = (kind_sel == 18);
        if (kind_sel == 19) begin
            al = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(41, 63));
            for (i = 0; i < $urandom_range(1, 3); i++) begin
                feed(8'($urandom_range(0, 255)), al, i == 0);
            end
        end else begin
            build_area(alen);
            if (kind_sel >= 15) begin
                for (i = 0; i < alen; i++) area_bytes[i] = 8'($urandom_range(0, 255));
            end
            if (kind_sel == 14) begin
                repeat ($urandom_range(1, 3))
                    area_bytes = {area_bytes, 8'($urandom_range(0, 255))};
            end
            for (i = 0; i < area_bytes.size(); i++) begin
                al = drift ? 6'($urandom_range(1, 44)) : 6'(alen);
                feed(area_bytes[i], al, (i == 0) && !no_first);
            end
        end
    endtask

    // receiver: random back-pressure, one long hold on request
    initial begin : rx_side
        int n;
        bit held;
        held = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_rx_req && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                for (n = 0; n < RX_LONG_HOLD; n++) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        tolp_pkg::t_result w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (option_reports_q.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h tlast %b",
                       m_axis_tdata, m_axis_tlast);
                n_mismatch++;
            end else begin
                w = option_reports_q.pop_front();
                if (m_axis_tdata[0] !== w.opt_valid) begin
                    $error("option_valid: expected %0d, got %0d", w.opt_valid, m_axis_tdata[0]);
                    n_mismatch++;
                end
                if (m_axis_tdata[8:1] !== w.kind) begin
                    $error("option_kind: expected %0d, got %0d", w.kind, m_axis_tdata[8:1]);
                    n_mismatch++;
                end
                if (m_axis_tdata[14:9] !== w.data_len) begin
                    $error("option_data_len: expected %0d, got %0d", w.data_len,
                           m_axis_tdata[14:9]);
                    n_mismatch++;
                end
                if (m_axis_tdata[15] !== w.wscale_big) begin
                    $error("wscale_too_big: expected %0d, got %0d", w.wscale_big,
                           m_axis_tdata[15]);
                    n_mismatch++;
                end
                if (m_axis_tlast !== w.done) begin
                    $error("area_done: expected %0d, got %0d", w.done, m_axis_tlast);
                    n_mismatch++;
                end
                if (m_axis_tdata[17:16] !== w.status) begin
                    $error("parse_status: expected %0d, got %0d", w.status,
                           m_axis_tdata[17:16]);
                    n_mismatch++;
                end
                if (m_axis_tdata[23:18] !== w.count) begin
                    $error("option_count: expected %0d, got %0d", w.count,
                           m_axis_tdata[23:18]);
                    n_mismatch++;
                end
                if (m_axis_tdata[25:24] !== w.cls) begin
                    $error("option_class: expected %0d, got %0d", w.cls,
                           m_axis_tdata[25:24]);
                    n_mismatch++;
                end
            end
        end
    end

    initial begin : tx_side
        int                i;
        bit                used;
        bit                has;
        tolp_pkg::t_result r;
        clear_parser();
        load_directed();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < dir_rows.size(); i++) begin
            send_byte(dir_rows[i].b, dir_rows[i].al, dir_rows[i].fb, used, has, r);
            if (dir_rows[i].typed) begin
                if (dir_rows[i].t_has) option_reports_q = {option_reports_q, dir_rows[i].t_r};
            end else if (has) begin
                option_reports_q = {option_reports_q, r};
            end
        end

        // drain before the random part
        s_axis_tvalid <= 1'b0;
        while (option_reports_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        hold_rx_req = 1'b1;
        n_used = 0;
        while (n_used < RANDOM_BYTES) begin
            if (n_used > RANDOM_BYTES - 150) quiet_tail = 1'b1;
            send_area();
        end

        s_axis_tvalid <= 1'b0;
        while (option_reports_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_mismatch == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/tolp_pkg.sv
sv/tolp_in_reg.sv
sv/tolp_step.sv
sv/tcp_option_list_parser_core.sv
verif/testbench.sv
